[hdl/irn_pkg.sv]
// Shared types and constants of the nearest-neighbor frame rotator.
`timescale 1ns / 1ps

package irn_pkg;

  localparam int MAX_SIDE_DEF = 512;
  localparam int SIDE_W       = 10;
  localparam int COORD_W      = 9;
  localparam int CHAN_W       = 8;
  localparam int PIX_W        = 3 * CHAN_W;
  localparam int Q14_W        = 16;
  localparam int FRAC_W       = 14;
  localparam int ONE_Q14      = 16384;
  localparam int HALF_Q14     = 8192;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE = 2'd0,
    CFG_COS  = 2'd1,
    CFG_SIN  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                 operation;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [CHAN_W-1:0]   red_in;
    logic [CHAN_W-1:0]   green_in;
    logic [CHAN_W-1:0]   blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              outside;
  } out_item_t;

endpackage

[hdl/image_rotate_nearest.sv]
// Nearest-neighbor rotation of a square RGB frame about its center.
`timescale 1ns / 1ps

// Takes one item per clock; busy_o never rises. A store item writes one pixel
// into the frame memory (stores outside the current side are dropped) and gives
// no result. A read item gives one result, on the result ports four cycles after
// the edge that accepts it: result_valid_o is high for exactly one cycle and the
// receiver cannot stall it, so results must be taken as they come. The rate is
// set by the single frame memory port, which serves one store or one read each
// cycle; stores and reads reach that port in the order they were accepted, so a
// read always sees every earlier store. Reading a frame position that was never
// stored gives an undefined pixel. Write the configuration only while no item
// is in flight.
module image_rotate_nearest #(
  parameter int MAX_SIDE = irn_pkg::MAX_SIDE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  irn_pkg::in_item_t                  item_i,
  output logic                               result_valid_o,
  output irn_pkg::out_item_t                 result_o,
  input  logic                               cfg_we_i,
  input  logic [irn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [irn_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int EW    = (SW > irn_pkg::SIDE_W) ? SW : irn_pkg::SIDE_W;
  localparam int DW    = EW + 1;                     // signed offset from center
  localparam int PW    = DW + irn_pkg::Q14_W;        // one product
  localparam int TW    = PW + 2;                     // sum of two products plus half
  localparam int QW    = TW - irn_pkg::FRAC_W;       // integer part
  localparam int RW    = QW + 1;                     // source coordinate
  localparam int CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int PXW   = irn_pkg::PIX_W;

  // configuration
  logic [irn_pkg::SIDE_W-1:0]       side_q;
  logic signed [irn_pkg::Q14_W-1:0] cos_q;
  logic signed [irn_pkg::Q14_W-1:0] sin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= irn_pkg::SIDE_W'(512);
      cos_q  <= irn_pkg::Q14_W'(irn_pkg::ONE_Q14);
      sin_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (irn_pkg::cfg_idx_e'(cfg_idx_i))
        irn_pkg::CFG_SIDE: side_q <= cfg_data_i[irn_pkg::SIDE_W-1:0];
        irn_pkg::CFG_COS:  cos_q  <= $signed(cfg_data_i);
        irn_pkg::CFG_SIN:  sin_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic [EW-1:0] eff_side;
  logic [EW-1:0] center;

  always_comb begin
    if (side_q == '0) begin
      eff_side = EW'(1);
    end else if (EW'(side_q) > EW'(MAX_SIDE)) begin
      eff_side = EW'(MAX_SIDE);
    end else begin
      eff_side = EW'(side_q);
    end
    center = (eff_side - EW'(1)) >> 1;
  end

  assign busy_o = 1'b0;

  // stage 1: captured item
  logic                         s1_valid_q;
  irn_pkg::op_e                 s1_op_q;
  logic [irn_pkg::COORD_W-1:0]  s1_row_q;
  logic [irn_pkg::COORD_W-1:0]  s1_col_q;
  logic [PXW-1:0]               s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_op_q  <= item_i.operation;
      s1_row_q <= item_i.row;
      s1_col_q <= item_i.col;
      s1_pix_q <= {item_i.red_in, item_i.green_in, item_i.blue_in};
    end
  end

  // stage 2: offsets from center times cos and sin
  logic signed [DW-1:0] dr;
  logic signed [DW-1:0] dc;
  logic signed [PW-1:0] m_rc, m_rs, m_cc, m_cs;

  always_comb begin
    dr   = $signed(DW'(s1_row_q)) - $signed(DW'(center));
    dc   = $signed(DW'(s1_col_q)) - $signed(DW'(center));
    m_rc = PW'(dr) * PW'(cos_q);
    m_rs = PW'(dr) * PW'(sin_q);
    m_cc = PW'(dc) * PW'(cos_q);
    m_cs = PW'(dc) * PW'(sin_q);
  end

  logic                         s2_valid_q;
  irn_pkg::op_e                 s2_op_q;
  logic [irn_pkg::COORD_W-1:0]  s2_row_q;
  logic [irn_pkg::COORD_W-1:0]  s2_col_q;
  logic [PXW-1:0]               s2_pix_q;
  logic signed [PW-1:0]         s2_rc_q, s2_rs_q, s2_cc_q, s2_cs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_op_q  <= s1_op_q;
      s2_row_q <= s1_row_q;
      s2_col_q <= s1_col_q;
      s2_pix_q <= s1_pix_q;
      s2_rc_q  <= m_rc;
      s2_rs_q  <= m_rs;
      s2_cc_q  <= m_cc;
      s2_cs_q  <= m_cs;
    end
  end

  // stage 3: rotated offsets in Q14 with half added
  logic signed [TW-1:0] t_u, t_v;

  always_comb begin
    t_u = TW'(s2_rc_q) - TW'(s2_cs_q) + TW'(irn_pkg::HALF_Q14);
    t_v = TW'(s2_rs_q) + TW'(s2_cc_q) + TW'(irn_pkg::HALF_Q14);
  end

  logic                         s3_valid_q;
  irn_pkg::op_e                 s3_op_q;
  logic [irn_pkg::COORD_W-1:0]  s3_row_q;
  logic [irn_pkg::COORD_W-1:0]  s3_col_q;
  logic [PXW-1:0]               s3_pix_q;
  logic signed [TW-1:0]         s3_tu_q, s3_tv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_op_q  <= s2_op_q;
      s3_row_q <= s2_row_q;
      s3_col_q <= s2_col_q;
      s3_pix_q <= s2_pix_q;
      s3_tu_q  <= t_u;
      s3_tv_q  <= t_v;
    end
  end

  // stage 4: divide by one in Q14 rounding toward zero, move back to frame coords.
  // A store simply carries its own row and column.
  logic signed [TW-1:0] tu_adj, tv_adj;
  logic signed [RW-1:0] src_r, src_c;

  always_comb begin
    tu_adj = s3_tu_q + (s3_tu_q[TW-1] ? TW'(irn_pkg::ONE_Q14 - 1) : TW'(0));
    tv_adj = s3_tv_q + (s3_tv_q[TW-1] ? TW'(irn_pkg::ONE_Q14 - 1) : TW'(0));
    if (s3_op_q == irn_pkg::OP_READ) begin
      src_r = RW'($signed(tu_adj[TW-1:irn_pkg::FRAC_W])) + $signed(RW'(center));
      src_c = RW'($signed(tv_adj[TW-1:irn_pkg::FRAC_W])) + $signed(RW'(center));
    end else begin
      src_r = $signed(RW'(s3_row_q));
      src_c = $signed(RW'(s3_col_q));
    end
  end

  logic                 s4_valid_q;
  irn_pkg::op_e         s4_op_q;
  logic [PXW-1:0]       s4_pix_q;
  logic signed [RW-1:0] s4_r_q, s4_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      s4_op_q  <= s3_op_q;
      s4_pix_q <= s3_pix_q;
      s4_r_q   <= src_r;
      s4_c_q   <= src_c;
    end
  end

  // stage 5: bounds test and the one frame memory access
  logic          s4_outside;
  logic [AW-1:0] s4_addr;
  logic          mem_we;

  always_comb begin
    s4_outside = s4_r_q[RW-1] || s4_c_q[RW-1] ||
                 ($unsigned(s4_r_q) >= RW'(eff_side)) ||
                 ($unsigned(s4_c_q) >= RW'(eff_side));
    s4_addr    = AW'(s4_r_q[CW-1:0]) * AW'(MAX_SIDE) + AW'(s4_c_q[CW-1:0]);
    mem_we     = s4_valid_q && (s4_op_q == irn_pkg::OP_STORE) && !s4_outside;
  end

  logic [PXW-1:0] frame_mem [DEPTH];
  logic [PXW-1:0] s5_pix_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[s4_addr] <= s4_pix_q;
    end else if (s4_valid_q) begin
      s5_pix_q <= frame_mem[s4_addr];
    end
  end

  logic s5_valid_q;
  logic s5_outside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= s4_valid_q && (s4_op_q == irn_pkg::OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_valid_q) begin
      s5_outside_q <= s4_outside;
    end
  end

  // outside positions give black
  assign result_valid_o = s5_valid_q;
  always_comb begin
    result_o.red_out   = s5_outside_q ? '0 : s5_pix_q[PXW-1 -: irn_pkg::CHAN_W];
    result_o.green_out = s5_outside_q ? '0 : s5_pix_q[irn_pkg::CHAN_W +: irn_pkg::CHAN_W];
    result_o.blue_out  = s5_outside_q ? '0 : s5_pix_q[irn_pkg::CHAN_W-1:0];
    result_o.outside   = s5_outside_q;
  end

endmodule

[sim/tb_image_rotate_nearest.sv]
// Self-checking testbench of the nearest-neighbor frame rotator.
`timescale 1ns / 1ps

module tb_image_rotate_nearest;

  localparam int FRAME_SIDE  = irn_pkg::MAX_SIDE_DEF;
  localparam int FRAME_WORDS = FRAME_SIDE * FRAME_SIDE;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASES       = 13;
  localparam int PHASE_ITEMS  = 96;

  typedef struct {
    bit                 is_cfg;
    logic [9:0]         side;
    logic [15:0]        cosv;
    logic [15:0]        sinv;
    irn_pkg::in_item_t  item;
    bit                 fixed;
    irn_pkg::out_item_t want;
  } plan_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  irn_pkg::in_item_t              item;
  logic                           res_valid;
  irn_pkg::out_item_t             res;
  logic                           cfg_we;
  irn_pkg::cfg_idx_e              cfg_idx;
  logic [irn_pkg::CFG_DATA_W-1:0] cfg_data;

  image_rotate_nearest u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .item_i         (item),
    .result_valid_o (res_valid),
    .result_o       (res),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  // Shadow of the block: registers and source frame
  logic [9:0]                cfg_side = 10'd512;
  logic signed [15:0]        cfg_cos  = 16'sd16384;
  logic signed [15:0]        cfg_sin  = 16'sd0;
  logic [irn_pkg::PIX_W-1:0] frame_pixel [FRAME_WORDS];
  bit                        frame_valid [FRAME_WORDS];

  irn_pkg::out_item_t expected_pixels [$];
  plan_row_t          plan [$];
  irn_pkg::out_item_t head_pixel;
  int                 mismatch_count = 0;
  int                 quiet_cycles   = 0;

  int cos_set [10] = '{16384, 0, -16384, 0, 11585, 14189, -11585, 32767, -32768, 16384};
  int sin_set [10] = '{0, 16384, 0, -16384, 11585, 8192, 11585, -32768, 32767, -16384};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int eff_side();
    if (cfg_side == 10'd0) return 1;
    if (cfg_side > 10'(FRAME_SIDE)) return FRAME_SIDE;
    return int'(cfg_side);
  endfunction

  // Source position that output (r, c) maps to; returns 1 when it lies in the frame
  function automatic bit locate_source(input logic [8:0] r, input logic [8:0] c,
                                       output int sr, output int sc);
    longint es, ctr, dr, dc, du, dv;
    es  = longint'(eff_side());
    ctr = (es - 1) / 2;
    dr  = longint'(r) - ctr;
    dc  = longint'(c) - ctr;
    du  = (dr * longint'(cfg_cos) - dc * longint'(cfg_sin) + irn_pkg::HALF_Q14)
          / irn_pkg::ONE_Q14;
    dv  = (dr * longint'(cfg_sin) + dc * longint'(cfg_cos) + irn_pkg::HALF_Q14)
          / irn_pkg::ONE_Q14;
    sr  = int'(du + ctr);
    sc  = int'(dv + ctr);
    return sr >= 0 && sc >= 0 && sr < es && sc < es;
  endfunction

  function automatic plan_row_t cfg_row(input int s, input int cv, input int sv);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.side   = 10'(s);
    r.cosv   = 16'(cv);
    r.sinv   = 16'(sv);
    return r;
  endfunction

  function automatic plan_row_t op_row(input irn_pkg::op_e op, input int rw, input int cl,
                                       input logic [23:0] px, input bit fixed = 1'b0,
                                       input irn_pkg::out_item_t want = '0);
    plan_row_t r;
    r = '{default: '0};
    r.item.operation = op;
    r.item.row       = 9'(rw);
    r.item.col       = 9'(cl);
    {r.item.red_in, r.item.green_in, r.item.blue_in} = px;
    r.fixed = fixed;
    r.want  = want;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input irn_pkg::out_item_t want,
                               input irn_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: want r=%h g=%h b=%h out=%b, got r=%h g=%h b=%h out=%b",
               $time, what, want.red_out, want.green_out, want.blue_out, want.outside,
               got.red_out, got.green_out, got.blue_out, got.outside);
  endtask

  // Drive one item; returns at the edge that accepts it. Called on a rising edge.
  task automatic push_item(input irn_pkg::in_item_t it);
    start <= 1'b1;
    item  <= it;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic record_store(input irn_pkg::in_item_t it);
    int idx;
    if (int'(it.row) < eff_side() && int'(it.col) < eff_side()) begin
      idx = int'(it.row) * FRAME_SIDE + int'(it.col);
      frame_pixel[idx] = {it.red_in, it.green_in, it.blue_in};
      frame_valid[idx] = 1'b1;
    end
  endtask

  task automatic apply_item(input irn_pkg::in_item_t it, input bit fixed,
                            input irn_pkg::out_item_t fixed_res);
    int                 sr, sc;
    bit                 in_frame;
    irn_pkg::in_item_t  fill;
    irn_pkg::out_item_t pixel;
    // never read a frame entry that was not stored: store it first
    if (it.operation == irn_pkg::OP_READ && !fixed) begin
      in_frame = locate_source(it.row, it.col, sr, sc);
      if (in_frame && !frame_valid[sr * FRAME_SIDE + sc]) begin
        fill.operation = irn_pkg::OP_STORE;
        fill.row       = 9'(sr);
        fill.col       = 9'(sc);
        fill.red_in    = 8'($urandom);
        fill.green_in  = 8'($urandom);
        fill.blue_in   = 8'($urandom);
        push_item(fill);
        record_store(fill);
      end
    end
    push_item(it);
    if (it.operation == irn_pkg::OP_STORE) begin
      record_store(it);
    end else begin
      if (fixed) begin
        pixel = fixed_res;
      end else if (locate_source(it.row, it.col, sr, sc)) begin
        pixel = {frame_pixel[sr * FRAME_SIDE + sc], 1'b0};
      end else begin
        pixel = {24'h0, 1'b1};
      end
      expected_pixels.push_back(pixel);
    end
  endtask

  // Registers change only with no read in flight
  task automatic load_config(input logic [9:0] s, input logic [15:0] cv,
                             input logic [15:0] sv);
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= irn_pkg::CFG_SIDE;
    cfg_data <= {6'($urandom), s};
    @(posedge clk);
    cfg_idx  <= irn_pkg::CFG_COS;
    cfg_data <= cv;
    @(posedge clk);
    cfg_idx  <= irn_pkg::CFG_SIN;
    cfg_data <= sv;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cfg_side = s;
    cfg_cos  = cv;
    cfg_sin  = sv;
  endtask

  always @(negedge clk) begin
    if (rst_n && res_valid) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch("result with no read pending", '0, res);
      end else begin
        head_pixel = expected_pixels.pop_front();
        if (res.red_out !== head_pixel.red_out || res.green_out !== head_pixel.green_out ||
            res.blue_out !== head_pixel.blue_out || res.outside !== head_pixel.outside)
          note_mismatch("pixel mismatch", head_pixel, res);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (start && !busy) || res_valid || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    irn_pkg::in_item_t it;
    int                es, kind, idle_pct, rot, side_pick;
    logic [15:0]       cv, sv;

    rst_n    = 1'b0;
    start    = 1'b0;
    item     = '0;
    cfg_we   = 1'b0;
    cfg_idx  = irn_pkg::CFG_SIDE;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: side 512, identity rotation
    plan.push_back(op_row(irn_pkg::OP_STORE, 511, 511, 24'hFFFFFF));
    plan.push_back(op_row(irn_pkg::OP_READ,  511, 511, 24'h0, 1'b1, {24'hFFFFFF, 1'b0}));
    plan.push_back(op_row(irn_pkg::OP_STORE, 1, 1, 24'h5AA53C));
    plan.push_back(op_row(irn_pkg::OP_READ,  0, 0, 24'hFFFFFF));   // rounds toward zero to (1,1)
    plan.push_back(op_row(irn_pkg::OP_STORE, 0, 0, 24'h000000));
    // side zero acts as a one-pixel frame
    plan.push_back(cfg_row(0, 16384, 0));
    plan.push_back(op_row(irn_pkg::OP_STORE, 0, 0, 24'hAA5501));
    plan.push_back(op_row(irn_pkg::OP_READ,  0, 0, 24'h0, 1'b1, {24'hAA5501, 1'b0}));
    plan.push_back(op_row(irn_pkg::OP_STORE, 0, 1, 24'h123456));  // outside the frame, dropped
    plan.push_back(op_row(irn_pkg::OP_READ,  0, 1, 24'h0, 1'b1, {24'h0, 1'b1}));
    plan.push_back(op_row(irn_pkg::OP_READ,  511, 511, 24'h0, 1'b1, {24'h0, 1'b1}));
    // oversized side clamps to the maximum; half turn
    plan.push_back(cfg_row(1023, -16384, 0));
    plan.push_back(op_row(irn_pkg::OP_READ,  511, 511, 24'h0));
    plan.push_back(op_row(irn_pkg::OP_READ,  255, 255, 24'h0));
    // quarter turn on a 4x4 frame
    plan.push_back(cfg_row(4, 0, 16384));
    plan.push_back(op_row(irn_pkg::OP_STORE, 3, 4, 24'hDEAD01));
    plan.push_back(op_row(irn_pkg::OP_STORE, 3, 3, 24'hC33C81));
    plan.push_back(op_row(irn_pkg::OP_READ,  511, 0, 24'h0, 1'b1, {24'h0, 1'b1}));
    plan.push_back(op_row(irn_pkg::OP_READ,  0, 0, 24'h0));
    // sine and cosine beyond +-1
    plan.push_back(cfg_row(3, 32767, -32768));
    plan.push_back(op_row(irn_pkg::OP_READ,  2, 2, 24'h0));
    plan.push_back(op_row(irn_pkg::OP_READ,  0, 2, 24'h0));
    plan.push_back(op_row(irn_pkg::OP_READ,  2, 0, 24'h0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) load_config(plan[i].side, plan[i].cosv, plan[i].sinv);
      else apply_item(plan[i].item, plan[i].fixed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: side_pick = 1;
        1: side_pick = 2;
        2: side_pick = 512;
        3: side_pick = 0;
        4: side_pick = 1023;
        default: side_pick = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 511)
                                                         : $urandom_range(3, 24);
      endcase
      rot = $urandom_range(0, 10);
      if (rot == 10) begin
        cv = 16'($urandom);
        sv = 16'($urandom);
      end else begin
        cv = 16'(cos_set[rot]);
        sv = 16'(sin_set[rot]);
      end
      load_config(10'(side_pick), cv, sv);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 87;
        default: idle_pct = 14;
      endcase
      es = eff_side();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        // hold off until every pending read has come back
        if ($urandom_range(0, 99) == 0) begin
          start <= 1'b0;
          @(posedge clk);
          while (expected_pixels.size() != 0) @(posedge clk);
        end
        kind = $urandom_range(0, 99);
        it.operation = (kind < 50) ? irn_pkg::OP_STORE : irn_pkg::OP_READ;
        if (kind < 45 || (kind >= 50 && kind < 90)) begin
          it.row = 9'($urandom_range(0, es - 1));
          it.col = 9'($urandom_range(0, es - 1));
        end else begin
          it.row = 9'($urandom);
          it.col = 9'($urandom);
        end
        it.red_in   = 8'($urandom);
        it.green_in = 8'($urandom);
        it.blue_in  = 8'($urandom);
        apply_item(it, 1'b0, '0);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[image_rotate_nearest.f]
hdl/irn_pkg.sv
hdl/image_rotate_nearest.sv
sim/tb_image_rotate_nearest.sv
